>>> rtl/sha_pkg.sv
// SHA-256 stream hasher package: types, constants, rotate helper.
// No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } core_state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam int         BLOCK_BYTES = 64;
  localparam int         QUEUE_DEPTH = 4;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

>>> rtl/sha_front.sv
// Front end: accepts input items, clamps the byte count, queues them.
// Depends on sha_pkg.
module sha_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [31:0]    data_word,
  input  logic [2:0]     byte_count,
  input  logic           last_word,
  output logic           q_valid,
  input  logic           q_take,
  output sha_pkg::item_t q_item
);
  localparam int AW = $clog2(sha_pkg::QUEUE_DEPTH);

  sha_pkg::item_t mem [sha_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;
  logic          push, pop;
  sha_pkg::item_t in_item;

  always_comb begin
    in_item.data = data_word;
    in_item.cnt  = (byte_count > 3'd4) ? 3'd4 : byte_count;
    in_item.last = last_word;
  end

  assign in_stall = (fill == (AW+1)'(sha_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

>>> rtl/sha_core.sv
// Back end: block assembly, padding, 64-round compression, digest output.
// Depends on sha_pkg.
module sha_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_take,
  input  sha_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    digest_word,
  output logic           digest_last
);
  sha_pkg::core_state_t state, state_next;

  logic [31:0] blk [16];
  logic [31:0] win [16];
  logic [31:0] hs  [8];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [5:0]  fill;
  logic [60:0] total;
  logic [5:0]  rnd;
  logic [2:0]  bpos;      // bytes of current item consumed
  logic        padding;   // in the tail of a message
  logic        pad_done;  // 0x80 already placed
  logic        need_len;  // this block carries the length
  logic [2:0]  oidx;

  // byte insertion path: one byte per cycle while taking item bytes or padding
  logic        byte_go, blk_full;
  logic [7:0]  byte_val;
  logic [3:0]  widx;
  logic [4:0]  sh;

  // 0x80 always goes in, even when the data ends right at the length slot
  always_comb begin
    byte_val = 8'h00;
    byte_go  = 1'b0;
    if (state == sha_pkg::ST_IDLE && q_valid && bpos < q_item.cnt) begin
      byte_go  = 1'b1;
      byte_val = q_item.data[5'(8 * (3 - bpos[1:0])) +: 8];
    end else if (state == sha_pkg::ST_PAD && (fill != sha_pkg::LEN_POS || !pad_done)) begin
      byte_go  = 1'b1;
      byte_val = pad_done ? 8'h00 : sha_pkg::PAD_MARK;
    end
  end

  assign widx     = fill[5:2];
  assign sh       = 5'(24 - 8 * fill[1:0]);
  assign blk_full = byte_go && (fill == 6'(sha_pkg::BLOCK_BYTES - 1));
  assign q_take   = (state == sha_pkg::ST_IDLE) && q_valid && (bpos >= q_item.cnt)
                    && !blk_full;

  // schedule and round
  logic [31:0] w, w15, w2, s0, s1, t1, t2;
  always_comb begin
    w15 = win[1];
    w2  = win[14];
    s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    w   = (rnd < 6'd16) ? win[0] : (win[0] + s0 + win[9] + s1);
    t1  = vh + (sha_pkg::rotr(ve, 6) ^ sha_pkg::rotr(ve, 11) ^ sha_pkg::rotr(ve, 25))
          + ((ve & vf) ^ (~ve & vg)) + sha_pkg::ROUND_K[rnd] + w;
    t2  = (sha_pkg::rotr(va, 2) ^ sha_pkg::rotr(va, 13) ^ sha_pkg::rotr(va, 22))
          + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  logic [63:0] bits;
  assign bits = {total, 3'b000};

  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (blk_full) state_next = sha_pkg::ST_ROUND;
        else if (q_take && q_item.last) state_next = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_PAD: begin
        if (blk_full) state_next = sha_pkg::ST_ROUND;
        else if (!byte_go) state_next = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: if (rnd == 6'd63) state_next = sha_pkg::ST_FOLD;
      sha_pkg::ST_FOLD: begin
        if (need_len) state_next = sha_pkg::ST_EMIT;
        else if (padding) state_next = sha_pkg::ST_PAD;
        else state_next = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_EMIT: if (!out_stall && oidx == 3'd7) state_next = sha_pkg::ST_IDLE;
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid   = (state == sha_pkg::ST_EMIT);
    digest_word = hs[oidx];
    digest_last = (oidx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (byte_go) begin
      if (fill[1:0] == 2'd0) blk[widx] <= {24'd0, byte_val} << sh;
      else blk[widx] <= blk[widx] | ({24'd0, byte_val} << sh);
    end
    if (state == sha_pkg::ST_PAD && !byte_go) begin
      blk[14] <= bits[63:32];
      blk[15] <= bits[31:0];
    end
    if (state == sha_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= w;
      {va, vb, vc, vd} <= {t1 + t2, va, vb, vc};
      {ve, vf, vg, vh} <= {vd + t1, ve, vf, vg};
    end else begin
      for (int i = 0; i < 14; i++) win[i] <= blk[i];
      if (state == sha_pkg::ST_PAD && !byte_go) begin
        win[14] <= bits[63:32];
        win[15] <= bits[31:0];
      end else begin
        win[14] <= blk[14];
        if (blk_full) win[15] <= (fill[1:0] == 2'd0) ? ({24'd0, byte_val} << sh)
                                                    : (blk[15] | ({24'd0, byte_val} << sh));
        else win[15] <= blk[15];
      end
      {va, vb, vc, vd, ve, vf, vg, vh} <= {hs[0], hs[1], hs[2], hs[3],
                                           hs[4], hs[5], hs[6], hs[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sha_pkg::ST_IDLE;
      fill     <= '0;
      total    <= '0;
      rnd      <= '0;
      bpos     <= '0;
      padding  <= 1'b0;
      pad_done <= 1'b0;
      need_len <= 1'b0;
      oidx     <= '0;
      for (int i = 0; i < 8; i++) hs[i] <= sha_pkg::INIT_H[i];
    end else begin
      state <= state_next;
      if (byte_go) begin
        fill <= fill + 6'd1;
        if (state == sha_pkg::ST_IDLE) begin
          bpos  <= bpos + 3'd1;
          total <= total + 61'd1;
        end else begin
          pad_done <= 1'b1;
        end
      end
      if (q_take) begin
        bpos <= '0;
        if (q_item.last) padding <= 1'b1;
      end
      if (state == sha_pkg::ST_PAD && !byte_go) need_len <= 1'b1;
      if (state == sha_pkg::ST_ROUND) rnd <= rnd + 6'd1;
      else rnd <= '0;
      if (state == sha_pkg::ST_FOLD) begin
        hs[0] <= hs[0] + va; hs[1] <= hs[1] + vb;
        hs[2] <= hs[2] + vc; hs[3] <= hs[3] + vd;
        hs[4] <= hs[4] + ve; hs[5] <= hs[5] + vf;
        hs[6] <= hs[6] + vg; hs[7] <= hs[7] + vh;
      end
      if (state == sha_pkg::ST_EMIT && !out_stall) begin
        oidx <= oidx + 3'd1;
        if (oidx == 3'd7) begin
          for (int i = 0; i < 8; i++) hs[i] <= sha_pkg::INIT_H[i];
          fill     <= '0;
          total    <= '0;
          padding  <= 1'b0;
          pad_done <= 1'b0;
          need_len <= 1'b0;
        end
      end
    end
  end
endmodule

>>> rtl/sha256_stream_hasher.sv
// Streaming SHA-256: bytes in, eight digest words out per message.
// Bytes are inserted one at a time and each item is retired after its last byte;
// each 64-byte block then runs 64 rounds plus a fold.
// A last item adds padding and one or two more blocks, then the eight digest words.
// Synchronous reset clears the queue and control and loads the initial hash.
// Depends on sha_pkg, sha_front, sha_core.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        digest_last
);
  logic           q_valid, q_take;
  sha_pkg::item_t q_item;

  // front: input queue decouples the caller from block processing
  sha_front u_front (
    .clk, .rst, .in_valid, .in_stall, .data_word, .byte_count, .last_word,
    .q_valid, .q_take, .q_item
  );

  // back: byte packer, padding, round engine and digest output
  sha_core u_core (
    .clk, .rst, .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .digest_word, .digest_last
  );

`ifndef SYNTHESIS
  // the core never takes from an empty queue
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take from empty queue");
  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word)) else $error("digest changed");
`endif
endmodule

>>> test/sha256_digest_checker.sv
// Digest checker for the SHA-256 stream hasher: watches both channels,
// computes expected digests from accepted items and compares results.
// Depends on sha_pkg for the round constants and initial hash values.
`timescale 1ns / 100ps
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic        digest_last,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } digest_t;

  logic [31:0] hv [8];
  logic [31:0] blk [16];
  int unsigned fill;
  logic [60:0] msg_bytes;
  digest_t     digest_q [$];

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wi, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        s0 = ror(w[(i-15)&15], 7) ^ ror(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3);
        s1 = ror(w[(i-2)&15], 17) ^ ror(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10);
        wi = w[i&15] + s0 + w[(i-7)&15] + s1;
        w[i&15] = wi;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[i] + wi;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endtask

  task automatic push_byte(logic [7:0] b);
    int unsigned sh;
    sh = 24 - 8 * (fill & 3);
    if ((fill & 3) == 0) blk[fill >> 2] = 32'(b) << sh;
    else blk[fill >> 2] |= 32'(b) << sh;
    fill++;
    if (fill >= sha_pkg::BLOCK_BYTES) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) hv[i] = sha_pkg::INIT_H[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = 0;
    msg_bytes = '0;
  endtask

  // absorb one accepted item; a last item queues the eight digest words
  task automatic absorb(logic [31:0] d, logic [2:0] c, logic l);
    int unsigned n;
    logic [63:0] bits;
    n = (c > 3'd4) ? 4 : int'(c);
    for (int i = 0; i < n; i++) begin
      push_byte(d[31 - 8*i -: 8]);
      msg_bytes++;
    end
    if (l) begin
      push_byte(sha_pkg::PAD_MARK);
      while (fill != sha_pkg::LEN_POS) push_byte(8'h00);
      bits = {msg_bytes, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) digest_q.push_back('{hv[i], i == 7});
      restart();
    end
  endtask

  assign pending = digest_q.size();

  initial begin
    fail_count = 0;
    restart();
  end

  always @(posedge clk) begin
    digest_t exp_d;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h last %b", digest_word, digest_last);
        end else begin
          exp_d = digest_q.pop_front();
          if (digest_word !== exp_d.word || digest_last !== exp_d.fin) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp %h/%b got %h/%b",
                       exp_d.word, exp_d.fin, digest_word, digest_last);
          end
        end
      end
      if (in_valid && !in_stall) absorb(data_word, byte_count, last_word);
    end
  end
endmodule

>>> test/tb_sha256_stream_hasher.sv
// Testbench top for the SHA-256 stream hasher: drives messages of varied
// length with random idling and gives the verdict. Depends on sha_pkg,
// sha256_stream_hasher and sha256_digest_checker.
`timescale 1ns / 100ps
module tb_sha256_stream_hasher;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          calm = 1'b0;        // no idling in the closing part

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_word(data_word), .byte_count(byte_count), .last_word(last_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .digest_last(digest_last)
  );

  sha256_digest_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_word(data_word), .byte_count(byte_count), .last_word(last_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .digest_last(digest_last),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in random bursts while not calm
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // present one item and hold it until accepted; a gap burst may come first
  task automatic send_item(logic [31:0] d, logic [2:0] c, logic l);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= d;
    byte_count <= c;
    last_word  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // message of nw full words, then a last word carrying tail bytes
  task automatic send_message(int nw, logic [2:0] tail);
    for (int i = 0; i < nw; i++) send_item($urandom, 3'd4, 1'b0);
    send_item($urandom, tail, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int nw;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, value extremes, short words mid-message,
    // oversized and zero byte counts, padding spilling into an extra block
    send_item(32'h0, 3'd0, 1'b1);
    send_item(32'h61626300, 3'd3, 1'b1);          // "abc"
    send_item(32'hffffffff, 3'd4, 1'b0);
    send_item(32'h00000000, 3'd4, 1'b0);
    send_item(32'h12345678, 3'd2, 1'b0);          // short word, not last
    send_item(32'hdeadbeef, 3'd0, 1'b0);          // ignored
    send_item(32'hcafef00d, 3'd7, 1'b0);          // treated as four
    send_item(32'hffffffff, 3'd5, 1'b1);
    send_message(13, 3'd3);                       // 55 bytes: one block
    send_message(13, 3'd4);                       // 56 bytes: extra block
    send_message(15, 3'd4);                       // exactly 64 bytes
    send_item(32'h0, 3'd6, 1'b1);

    drain();                                      // sender holds off

    // random messages, mostly short, some over several blocks
    for (int m = 0; m < 14; m++) begin
      if (m == 11) calm = 1'b1;
      nw = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 16);
      for (int i = 0; i < nw; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item($urandom, 3'($urandom_range(0, 7)), 1'b0);
        else
          send_item($urandom, 3'd4, 1'b0);
      end
      send_item($urandom, 3'($urandom_range(0, 7)), 1'b1);
    end

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
